// ===== sv/mct_pkg.sv =====
// Package for the match/capture timer: item and result beat types, operation
// codes, register offsets and field constants. No dependencies.
package mct_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_CAP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [1:0]  cap_line;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic [3:0]  match_pins;
  } out_item_t;

  localparam logic [3:0] REG_FLAGS    = 4'd0;
  localparam logic [3:0] REG_RUN      = 4'd1;
  localparam logic [3:0] REG_COUNT    = 4'd2;
  localparam logic [3:0] REG_PLIMIT   = 4'd3;
  localparam logic [3:0] REG_PCOUNT   = 4'd4;
  localparam logic [3:0] REG_MCTL     = 4'd5;
  localparam logic [3:0] REG_MATCH0   = 4'd6;
  localparam logic [3:0] REG_CCTL     = 4'd10;
  localparam logic [3:0] REG_CAPTURE0 = 4'd11;
  localparam logic [3:0] REG_EXT      = 4'd15;

  localparam int RUN_ENABLE = 0;
  localparam int RUN_RESET  = 1;

  localparam int FLAG_W    = 8;
  localparam int CTL_W     = 12;
  localparam int PIN_W     = 4;
  localparam int CAP_FLAG0 = 4;

  localparam logic [1:0] PIN_NONE   = 2'd0;
  localparam logic [1:0] PIN_LOW    = 2'd1;
  localparam logic [1:0] PIN_HIGH   = 2'd2;
  localparam logic [1:0] PIN_TOGGLE = 2'd3;

endpackage

// ===== sv/match_capture_timer_top.sv =====
// Match/capture timer: 32-bit counter behind a 32-bit prescaler with match
// and capture channels; one item beat in, one result beat out.
// Path from input beat to result beat: input register, execute, result register.
// Throughput: one item per cycle; input stalls only while a held result is stalled.
// Reset: synchronous, active low; clears all timer state, pins and levels.
// Depends on mct_pkg, mct_in_stage, mct_core, mct_out_stage.
module match_capture_timer_top #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mct_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mct_pkg::out_item_t out_data
);

  logic               item_valid;
  mct_pkg::in_item_t  item;
  logic               out_ready;
  logic               exec;
  mct_pkg::out_item_t result;

  assign exec = item_valid && out_ready;

  mct_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (exec),
    .item_valid (item_valid),
    .item       (item)
  );

  mct_core #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .exec   (exec),
    .item   (item),
    .result (result)
  );

  mct_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (exec),
    .result    (result),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sv/mct_in_stage.sv =====
// Input register of the match/capture timer: holds one accepted item beat
// until the execute step takes it. Depends on mct_pkg.
module mct_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mct_pkg::in_item_t in_data,
  input  logic              take,
  output logic              item_valid,
  output mct_pkg::in_item_t item
);

  logic              valid_r;
  logic              valid_nxt;
  mct_pkg::in_item_t item_r;
  logic              load;

  assign in_stall   = valid_r && !take;
  assign load       = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

endmodule

// ===== sv/mct_core.sv =====
// Register file and execute logic of the match/capture timer: applies one
// item per enabled cycle and forms its result. Depends on mct_pkg.
module mct_core #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               exec,
  input  mct_pkg::in_item_t  item,
  output mct_pkg::out_item_t result
);

  logic [mct_pkg::FLAG_W-1:0] flags_r, flags_nxt;
  logic [1:0]                 run_r, run_nxt;
  logic [31:0]                cnt_r, cnt_nxt;
  logic [31:0]                plim_r, plim_nxt;
  logic [31:0]                pcnt_r, pcnt_nxt;
  logic [mct_pkg::CTL_W-1:0]  mctl_r, mctl_nxt;
  logic [mct_pkg::CTL_W-1:0]  cctl_r, cctl_nxt;
  logic [mct_pkg::CTL_W-1:0]  ext_r, ext_nxt;
  logic [31:0]                mval_r [NUM_CHANNELS];
  logic [31:0]                mval_nxt [NUM_CHANNELS];
  logic [31:0]                cval_r [NUM_CHANNELS];
  logic [31:0]                cval_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]    lvl_r, lvl_nxt;
  logic [31:0]                rd;
  logic [mct_pkg::PIN_W-1:0]  pins;

  always_comb begin
    logic [31:0] cnt_inc;
    logic [2:0]  act;
    logic [1:0]  ext;
    flags_nxt = flags_r;
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    plim_nxt  = plim_r;
    pcnt_nxt  = pcnt_r;
    mctl_nxt  = mctl_r;
    cctl_nxt  = cctl_r;
    ext_nxt   = ext_r;
    lvl_nxt   = lvl_r;
    mval_nxt  = mval_r;
    cval_nxt  = cval_r;
    rd        = '0;
    cnt_inc   = cnt_r + 32'd1;
    act       = '0;
    ext       = '0;
    unique case (item.op)
      mct_pkg::OP_TICK: begin
        if (run_r[mct_pkg::RUN_ENABLE] && !run_r[mct_pkg::RUN_RESET]) begin
          if (pcnt_r >= plim_r) begin
            pcnt_nxt = '0;
            cnt_nxt  = cnt_inc;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (mval_r[i] != '0 && mval_r[i] == cnt_inc) begin
                act = mctl_r[3*i +: 3];
                ext = ext_r[mct_pkg::PIN_W + 2*i +: 2];
                if (act[0]) flags_nxt[i] = 1'b1;
                if (act[1]) cnt_nxt = '0;
                if (act[2]) run_nxt[mct_pkg::RUN_ENABLE] = 1'b0;
                unique case (ext)
                  mct_pkg::PIN_NONE:   ;
                  mct_pkg::PIN_LOW:    ext_nxt[i] = 1'b0;
                  mct_pkg::PIN_HIGH:   ext_nxt[i] = 1'b1;
                  mct_pkg::PIN_TOGGLE: ext_nxt[i] = !ext_r[i];
                  default:             ;
                endcase
              end
            end
          end else begin
            pcnt_nxt = pcnt_r + 32'd1;
          end
        end
      end
      mct_pkg::OP_READ: begin
        unique case (item.reg_index)
          mct_pkg::REG_FLAGS:  rd = 32'(flags_r);
          mct_pkg::REG_RUN:    rd = 32'(run_r);
          mct_pkg::REG_COUNT:  rd = cnt_r;
          mct_pkg::REG_PLIMIT: rd = plim_r;
          mct_pkg::REG_PCOUNT: rd = pcnt_r;
          mct_pkg::REG_MCTL:   rd = 32'(mctl_r);
          mct_pkg::REG_CCTL:   rd = 32'(cctl_r);
          mct_pkg::REG_EXT:    rd = 32'(ext_r);
          default: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (item.reg_index == mct_pkg::REG_MATCH0 + 4'(i)) rd = mval_r[i];
              if (item.reg_index == mct_pkg::REG_CAPTURE0 + 4'(i)) rd = cval_r[i];
            end
          end
        endcase
      end
      mct_pkg::OP_WRITE: begin
        unique case (item.reg_index)
          mct_pkg::REG_FLAGS: begin
            flags_nxt = flags_r & ~item.write_data[mct_pkg::FLAG_W-1:0];
          end
          mct_pkg::REG_RUN: begin
            run_nxt = item.write_data[1:0];
            if (item.write_data[mct_pkg::RUN_RESET]) begin
              cnt_nxt  = '0;
              pcnt_nxt = '0;
            end
          end
          mct_pkg::REG_PLIMIT: plim_nxt = item.write_data;
          mct_pkg::REG_MCTL:   mctl_nxt = item.write_data[mct_pkg::CTL_W-1:0];
          mct_pkg::REG_CCTL:   cctl_nxt = item.write_data[mct_pkg::CTL_W-1:0];
          mct_pkg::REG_EXT: begin
            ext_nxt = {item.write_data[mct_pkg::CTL_W-1:mct_pkg::PIN_W],
                       ext_r[mct_pkg::PIN_W-1:0]};
          end
          default: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (item.reg_index == mct_pkg::REG_MATCH0 + 4'(i)) begin
                mval_nxt[i] = item.write_data;
              end
            end
          end
        endcase
      end
      mct_pkg::OP_CAP: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (item.cap_line == 2'(i)) begin
            act = cctl_r[3*i +: 3];
            if ((act[0] && !lvl_r[i] && item.write_data[0]) ||
                (act[1] && lvl_r[i] && !item.write_data[0])) begin
              cval_nxt[i] = cnt_r;
              if (act[2]) flags_nxt[mct_pkg::CAP_FLAG0 + i] = 1'b1;
            end
            lvl_nxt[i] = item.write_data[0];
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    pins = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      pins[i] = ext_nxt[i];
    end
  end

  assign result.read_data  = rd;
  assign result.irq        = |flags_nxt;
  assign result.match_pins = pins;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      run_r   <= '0;
      cnt_r   <= '0;
      plim_r  <= '0;
      pcnt_r  <= '0;
      mctl_r  <= '0;
      cctl_r  <= '0;
      ext_r   <= '0;
      lvl_r   <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        mval_r[i] <= '0;
        cval_r[i] <= '0;
      end
    end else if (exec) begin
      flags_r <= flags_nxt;
      run_r   <= run_nxt;
      cnt_r   <= cnt_nxt;
      plim_r  <= plim_nxt;
      pcnt_r  <= pcnt_nxt;
      mctl_r  <= mctl_nxt;
      cctl_r  <= cctl_nxt;
      ext_r   <= ext_nxt;
      lvl_r   <= lvl_nxt;
      mval_r  <= mval_nxt;
      cval_r  <= cval_nxt;
    end
  end

endmodule

// ===== sv/mct_out_stage.sv =====
// Result register of the match/capture timer: holds a result beat until the
// receiver takes it. Depends on mct_pkg.
module mct_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  mct_pkg::out_item_t result,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_stall,
  output mct_pkg::out_item_t out_data
);

  logic               valid_r;
  logic               valid_nxt;
  mct_pkg::out_item_t data_r;

  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

// ===== sv/mct_checker.sv =====
// Port checker for the match/capture timer top level, with its bind.
// Depends on mct_pkg and match_capture_timer_top.
module mct_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input mct_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_delivery: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted beat produced no result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("outputs active after reset");

endmodule

bind match_capture_timer_top mct_checker u_mct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
